### hdl/tlpd_pkg.sv
// Package for the typed length-prefixed deframer: phase, result codes,
// reset values and the two fixed type-name tables.
// No dependencies; imported by typed_length_prefixed_deframer_unit.
package tlpd_pkg;

    localparam int TYPE_NAME_BYTES_DEF = 21;
    localparam int NAME_TABLE_DEPTH    = 64;
    localparam int NAME_IDX_W          = $clog2(NAME_TABLE_DEPTH);
    localparam int CFG_DATA_W          = 32;
    localparam int CFG_INDEX_W         = 1;

    localparam logic [15:0] MAX_LENGTH_RST     = 16'd1500;
    localparam logic [31:0] EXPECTED_CHECK_RST = 32'd1609676181;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_LENGTH     = 1'd0,
        REG_EXPECTED_CHECK = 1'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_NAME    = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CHECK   = 3'd3,
        PH_ERROR   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_LENGTH    = 3'd1,
        ERR_NAME_LEN  = 3'd2,
        ERR_NAME      = 3'd3,
        ERR_CHECK     = 3'd4
    } err_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       message_type;
        err_t       error_code;
        logic       last_of_frame;
    } result_t;

    // First type name, zero padded to the table depth.
    function automatic logic [7:0] type_a_byte(input logic [NAME_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'h6D;
            6'd1:    b = 8'h6F;
            6'd2:    b = 8'h6E;
            6'd3:    b = 8'h67;
            6'd4:    b = 8'h6F;
            6'd5:    b = 8'h2E;
            6'd6:    b = 8'h50;
            6'd7:    b = 8'h6C;
            6'd8:    b = 8'h61;
            6'd9:    b = 8'h79;
            6'd10:   b = 8'h65;
            6'd11:   b = 8'h72;
            6'd12:   b = 8'h4D;
            6'd13:   b = 8'h6F;
            6'd14:   b = 8'h76;
            6'd15:   b = 8'h65;
            6'd16:   b = 8'h44;
            6'd17:   b = 8'h61;
            6'd18:   b = 8'h74;
            6'd19:   b = 8'h61;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Second type name, zero padded to the table depth.
    function automatic logic [7:0] type_b_byte(input logic [NAME_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'h6D;
            6'd1:    b = 8'h6F;
            6'd2:    b = 8'h6E;
            6'd3:    b = 8'h67;
            6'd4:    b = 8'h6F;
            6'd5:    b = 8'h2E;
            6'd6:    b = 8'h53;
            6'd7:    b = 8'h70;
            6'd8:    b = 8'h61;
            6'd9:    b = 8'h77;
            6'd10:   b = 8'h6E;
            6'd11:   b = 8'h45;
            6'd12:   b = 8'h6E;
            6'd13:   b = 8'h65;
            6'd14:   b = 8'h6D;
            6'd15:   b = 8'h79;
            6'd16:   b = 8'h44;
            6'd17:   b = 8'h61;
            6'd18:   b = 8'h74;
            6'd19:   b = 8'h61;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hdl/typed_length_prefixed_deframer_unit.sv
// Top level of the typed length-prefixed deframer: frame parser, output
// register with a one-word skid stage, and configuration registers.
// Depends on tlpd_pkg.
//
// Usage: the input channel (in_valid, in_stall, rx_byte) carries the received
// stream, one byte per word. A frame is a 4-byte big-endian length, a 4-byte
// name length, the name, the payload and a 4-byte check word. The output
// channel (out_valid, out_stall and the result fields) carries one word per
// payload byte, tagged with its message type, and one accept or error word
// that ends the frame. Header, name and check bytes give no output word.
// Throughput is one byte per cycle while in_stall is low; the per-byte
// parser is a single registered pass, so a result word enters the output
// register, or the skid stage behind a stalled output word, at the same
// edge that takes its byte. When the receiver stalls, one more result is
// caught in the skid stage and in_stall then rises until it drains; bytes
// keep flowing as long as the skid stage is empty.
// Reset clears the parser to the start of a frame, empties both output
// stages and loads max_length = 1500 and the default expected check word.
// After any error the parser swallows every further byte until reset.
// cfg_write with cfg_index 0 writes max_length (low 16 bits of cfg_data),
// index 1 writes expected_check; write only while the block is idle.
module typed_length_prefixed_deframer_unit
    import tlpd_pkg::*;
#(
    parameter int TYPE_NAME_BYTES = TYPE_NAME_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             kind,
    output logic [7:0]             payload_byte,
    output logic                   message_type,
    output logic [2:0]             error_code,
    output logic                   last_of_frame,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int NLW = $clog2(TYPE_NAME_BYTES + 1);

    logic [15:0]    max_length_reg;
    logic [31:0]    expected_check_reg;

    phase_t         phase_reg, phase_next;
    logic [15:0]    count_reg, count_next;
    logic [31:0]    frame_len_reg, frame_len_next;
    logic [NLW-1:0] name_len_reg, name_len_next;
    logic [31:0]    shift_reg, shift_next;
    logic [1:0]     flags_reg, flags_next;
    logic           type_reg, type_next;
    logic [15:0]    pay_len_reg, pay_len_next;

    result_t        out_reg, out_next, skid_reg, skid_next, res;
    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    logic           res_valid;
    logic           accept;

    // Values used by the parser.
    logic [31:0]    shifted;
    logic [31:0]    n_word;
    logic [15:0]    count_inc;
    logic [NAME_IDX_W-1:0] name_idx;
    logic [1:0]     flags_upd;
    logic [15:0]    pay_len_calc;

    assign accept   = in_valid && !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    assign shifted   = {shift_reg[23:0], rx_byte};
    assign n_word    = shifted;
    assign count_inc = count_reg + 16'd1;
    assign name_idx  = NAME_IDX_W'(count_reg);

    always_comb
    begin
        flags_upd = flags_reg;
        if (rx_byte != type_a_byte(name_idx))
        begin
            flags_upd[0] = 1'b0;
        end
        if (rx_byte != type_b_byte(name_idx))
        begin
            flags_upd[1] = 1'b0;
        end
    end

    // The frame length has already passed the limit check, so it fits 16 bits.
    always_comb
    begin
        if (phase_reg == PH_HEADER)
        begin
            pay_len_calc = frame_len_reg[15:0] - 16'd8 - 16'(n_word[NLW-1:0]);
        end
        else
        begin
            pay_len_calc = frame_len_reg[15:0] - 16'd8 - 16'(name_len_reg);
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        frame_len_next = frame_len_reg;
        name_len_next  = name_len_reg;
        shift_next     = shift_reg;
        flags_next     = flags_reg;
        type_next      = type_reg;
        pay_len_next   = pay_len_reg;
        res_valid      = 1'b0;
        res            = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, message_type: 1'b0,
                           error_code: ERR_NONE, last_of_frame: 1'b0};

        case (phase_reg)
            PH_HEADER:
            begin
                shift_next = shifted;
                if (count_reg == 16'd3)
                begin
                    frame_len_next = shifted;
                end
                if (count_reg < 16'd7)
                begin
                    count_next = count_inc;
                end
                else
                begin
                    count_next = 16'd0;
                    shift_next = 32'd0;
                    flags_next = 2'b11;
                    name_len_next = n_word[NLW-1:0];
                    if (frame_len_reg > {16'd0, max_length_reg})
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                        res.error_code = ERR_LENGTH;
                        res.last_of_frame = 1'b1;
                    end
                    else if (n_word > 32'(TYPE_NAME_BYTES) ||
                             (32'd8 + n_word) > frame_len_reg)
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                        res.error_code = ERR_NAME_LEN;
                        res.last_of_frame = 1'b1;
                    end
                    else if (n_word == 32'd0)
                    begin
                        // An empty name is a prefix of the first type name.
                        type_next    = 1'b0;
                        pay_len_next = pay_len_calc;
                        phase_next   = (pay_len_calc == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_NAME;
                    end
                end
            end

            PH_NAME:
            begin
                flags_next = flags_upd;
                if (count_inc < 16'(name_len_reg))
                begin
                    count_next = count_inc;
                end
                else
                begin
                    count_next   = 16'd0;
                    pay_len_next = pay_len_calc;
                    if (flags_upd[0] || flags_upd[1])
                    begin
                        type_next  = !flags_upd[0];
                        phase_next = (pay_len_calc == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                        res.error_code = ERR_NAME;
                        res.last_of_frame = 1'b1;
                    end
                end
            end

            PH_PAYLOAD:
            begin
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
                res.message_type = type_reg;
                count_next       = count_inc;
                if (count_inc >= pay_len_reg)
                begin
                    count_next = 16'd0;
                    shift_next = 32'd0;
                    phase_next = PH_CHECK;
                end
            end

            PH_CHECK:
            begin
                shift_next = shifted;
                if (count_reg < 16'd3)
                begin
                    count_next = count_inc;
                end
                else if (shifted != expected_check_reg)
                begin
                    phase_next = PH_ERROR;
                    res_valid  = 1'b1;
                    res.kind   = KIND_ERROR;
                    res.error_code = ERR_CHECK;
                    res.last_of_frame = 1'b1;
                end
                else
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_ACCEPT;
                    res.message_type  = type_reg;
                    res.last_of_frame = 1'b1;
                    phase_next = PH_HEADER;
                    count_next = 16'd0;
                    shift_next = 32'd0;
                    flags_next = 2'b11;
                    type_next  = 1'b0;
                end
            end

            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    // Output register with a skid stage behind it.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = res;
                skid_valid_next = accept && res_valid;
            end
            else
            begin
                out_next       = res;
                out_valid_next = accept && res_valid;
            end
        end
        else if (accept && res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            count_reg      <= 16'd0;
            frame_len_reg  <= 32'd0;
            name_len_reg   <= '0;
            shift_reg      <= 32'd0;
            flags_reg      <= 2'b11;
            type_reg       <= 1'b0;
            pay_len_reg    <= 16'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                frame_len_reg <= frame_len_next;
                name_len_reg  <= name_len_next;
                shift_reg     <= shift_next;
                flags_reg     <= flags_next;
                type_reg      <= type_next;
                pay_len_reg   <= pay_len_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg     <= MAX_LENGTH_RST;
            expected_check_reg <= EXPECTED_CHECK_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_LENGTH:     max_length_reg     <= cfg_data[15:0];
                REG_EXPECTED_CHECK: expected_check_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign payload_byte  = out_reg.payload_byte;
    assign message_type  = out_reg.message_type;
    assign error_code    = out_reg.error_code;
    assign last_of_frame = out_reg.last_of_frame;

    // The skid stage only fills behind a held output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a word while the output register is empty");

    // An error word always ends its frame and carries a nonzero code.
    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_ERROR) |->
        (out_reg.last_of_frame && out_reg.error_code != ERR_NONE))
        else $error("error word without end of frame or error code");

    // The name phase is entered only with a nonempty name.
    a_name_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NAME) |-> (name_len_reg != '0))
        else $error("name phase with zero name length");

    // Once in the error phase the parser stays there.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR) |=> (phase_reg == PH_ERROR))
        else $error("parser left the error phase without reset");

endmodule
